### rtl/core/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Shared constants for the arctan series summation block: field widths,
// default parameter values and result status codes.
// ----------------------------------------------------------------------------
package ats_pkg;

    // payload field widths
    localparam int ACT_W = 1;
    localparam int X_W   = 32;
    localparam int CNT_W = 13;
    localparam int TOL_W = 31;
    localparam int ST_W  = 2;

    // magnitude of a clamped term or product
    localparam int MAG_W = 31;

    // defaults of the top-level parameters
    localparam int unsigned DEF_MAX_TERMS = 4096;
    localparam int unsigned DEF_FRAC_BITS = 29;

    // action codes
    localparam logic [ACT_W-1:0] ACT_COUNT = 1'b0;
    localparam logic [ACT_W-1:0] ACT_TOL   = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_LIMIT = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

endpackage

### rtl/core/ats_if.sv
// ----------------------------------------------------------------------------
// ats_if
// Valid/ready channels of the arctan series block: the argument request and
// the series sum response.
// ----------------------------------------------------------------------------
interface ats_in_if;
    import ats_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [X_W-1:0]   x_value;
    logic [CNT_W-1:0]        term_count;
    logic [TOL_W-1:0]        tolerance;

    modport source (output valid, action, x_value, term_count, tolerance, input ready);
    modport sink   (input valid, action, x_value, term_count, tolerance, output ready);
endinterface

interface ats_out_if;
    import ats_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   sum_value;
    logic [ST_W-1:0]         status;

    modport source (output valid, sum_value, status, input ready);
    modport sink   (input valid, sum_value, status, output ready);
endinterface

### rtl/core/ats_div.sv
// ----------------------------------------------------------------------------
// ats_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle. A start
// pulse loads the operands; done pulses as the last bit enters the quotient.
// ----------------------------------------------------------------------------
module ats_div #(
    parameter int DW = 46,
    parameter int VW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int KW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dsr;
    logic [VW:0]   w_trial;
    logic          w_fit;
    logic [VW:0]   w_diff;

    // trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/arctan_series_sum.sv
// ----------------------------------------------------------------------------
// arctan_series_sum
// Maclaurin series of arctan(x) in signed fixed point. Terms follow by the
// recurrence term *= -x*x*(2i-1)/(2i+1) on one shared 32x32 multiplier and
// an iterative divider; the sum and step products saturate with a flag.
//
//   channel  dir  handshake        payload
//   i_req    in   valid / ready    action, x_value, term_count, tolerance
//   o_rsp    out  valid / ready    sum_value, status
//
// the time per term is set mostly by the bit-serial divide by 2i+1, with
// DW = 33 + clog2(MAX_TERMS+2) quotient bits, 46 by default
// i_req.ready is low while a series is in progress
// a finished result waits in the output register; the next item is taken
// while it waits, and the block holds only if a second result is ready first
// synchronous active-low reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module arctan_series_sum #(
    parameter int unsigned MAX_TERMS = ats_pkg::DEF_MAX_TERMS,
    parameter int unsigned FRAC_BITS = ats_pkg::DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ats_in_if.sink    i_req,
    ats_out_if.source o_rsp
);
    import ats_pkg::*;

    localparam int IW = $clog2(MAX_TERMS + 2);
    localparam int NW = IW + 1;
    localparam int DW = MAG_W + NW + 1;
    localparam int CW = (IW > CNT_W) ? IW : CNT_W;
    localparam int PW = 2 * X_W;
    localparam int SW = X_W + 2;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHECK  = 11'b000_0000_0010,
        S_ADD    = 11'b000_0000_0100,
        S_MUL1   = 11'b000_0000_1000,
        S_RND1   = 11'b000_0001_0000,
        S_MUL2   = 11'b000_0010_0000,
        S_RND2   = 11'b000_0100_0000,
        S_MUL3   = 11'b000_1000_0000,
        S_DSTART = 11'b001_0000_0000,
        S_DIV    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_out_valid;
    logic [ACT_W-1:0]      r_action;
    logic                  r_neg;
    logic [X_W-1:0]        r_ax;
    logic [X_W-1:0]        r_mag;
    logic [MAG_W-1:0]      r_p;
    logic [PW-1:0]         r_prod;
    logic signed [X_W-1:0] r_sum;
    logic [TOL_W-1:0]      r_tol;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_n;
    logic                  r_sat;
    logic                  r_limit;
    logic signed [X_W-1:0] r_out_sum;
    logic [ST_W-1:0]       r_out_status;

    logic                  w_accept;
    logic                  w_load_out;
    logic [X_W-1:0]        w_in_ax;
    logic [CW-1:0]         w_cnt_ext;
    logic [IW-1:0]         w_in_n;
    logic [X_W-1:0]        w_mul_a;
    logic [X_W-1:0]        w_mul_b;
    logic [NW-1:0]         w_num;
    logic [NW-1:0]         w_den;
    logic [DW-1:0]         w_dividend;
    logic                  w_div_done;
    logic [DW-1:0]         w_quo;
    logic [PW:0]           w_rnd;
    logic [PW:0]           w_shr;
    logic                  w_rsat;
    logic [MAG_W-1:0]      w_rmag;
    logic [SW-1:0]         w_sum_ext;
    logic [SW-1:0]         w_addend;
    logic [SW-1:0]         w_add;
    logic                  w_add_hi;
    logic                  w_add_lo;
    logic [X_W-1:0]        w_add_sat;
    logic                  w_above_tol;
    logic                  w_more;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // magnitude of the argument and clipped term count
    assign w_in_ax   = i_req.x_value[X_W-1] ? (~i_req.x_value + X_W'(1)) : i_req.x_value;
    assign w_cnt_ext = CW'(i_req.term_count);
    assign w_in_n    = (w_cnt_ext > CW'(MAX_TERMS)) ? IW'(MAX_TERMS) : IW'(w_cnt_ext);

    // recurrence ratio terms for step i
    assign w_num      = {r_idx, 1'b0} - NW'(1);
    assign w_den      = {r_idx, 1'b1};
    assign w_dividend = r_prod[DW-1:0] + DW'(r_idx);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MUL1: begin
                w_mul_a = r_mag;
                w_mul_b = r_ax;
            end
            S_MUL2: begin
                w_mul_a = {1'b0, r_p};
                w_mul_b = r_ax;
            end
            default: begin
                w_mul_a = {1'b0, r_p};
                w_mul_b = X_W'(w_num);
            end
        endcase
    end

    // round to nearest and clamp a step product
    assign w_rnd  = {1'b0, r_prod} + ((PW + 1)'(1) << (FRAC_BITS - 1));
    assign w_shr  = w_rnd >> FRAC_BITS;
    assign w_rsat = |w_shr[PW:MAG_W];
    assign w_rmag = w_rsat ? {MAG_W{1'b1}} : w_shr[MAG_W-1:0];

    // saturating add of the signed term to the sum
    assign w_sum_ext = {{2{r_sum[X_W-1]}}, r_sum};
    assign w_addend  = {2'b00, r_mag};
    assign w_add     = r_neg ? (w_sum_ext - w_addend) : (w_sum_ext + w_addend);
    assign w_add_hi  = !w_add[SW-1] && (|w_add[SW-2:X_W-1]);
    assign w_add_lo  = w_add[SW-1] && !(&w_add[SW-2:X_W-1]);
    assign w_add_sat = w_add_hi ? {1'b0, {(X_W-1){1'b1}}} :
                       w_add_lo ? {1'b1, {(X_W-1){1'b0}}} : w_add[X_W-1:0];

    // loop tests
    assign w_above_tol = (r_mag > {1'b0, r_tol});
    assign w_more      = (r_idx <= IW'(MAX_TERMS));

    ats_div #(
        .DW (DW),
        .VW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (w_dividend),
        .i_divisor  (w_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.action == ACT_TOL) begin
                        n_state = S_CHECK;
                    end else if (w_in_n > IW'(1)) begin
                        n_state = S_MUL1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                n_state = (w_above_tol && w_more) ? S_ADD : S_DONE;
            end
            S_ADD: begin
                if (r_action == ACT_TOL) begin
                    n_state = S_MUL1;
                end else begin
                    n_state = ((r_idx + IW'(1)) < r_n) ? S_MUL1 : S_DONE;
                end
            end
            S_MUL1:   n_state = S_RND1;
            S_RND1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_RND2;
            S_RND2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = (r_action == ACT_TOL) ? S_CHECK : S_ADD;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // series datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_action <= i_req.action;
                r_neg    <= i_req.x_value[X_W-1];
                r_ax     <= w_in_ax;
                r_mag    <= w_in_ax;
                r_tol    <= i_req.tolerance;
                r_n      <= w_in_n;
                r_idx    <= IW'(1);
                r_sat    <= 1'b0;
                r_limit  <= 1'b0;
                r_sum    <= (i_req.action == ACT_TOL) ? '0 : i_req.x_value;
            end
            S_CHECK: begin
                r_limit <= w_above_tol;
            end
            S_ADD: begin
                r_sum <= w_add_sat;
                if (w_add_hi || w_add_lo) begin
                    r_sat <= 1'b1;
                end
                if (r_action == ACT_COUNT) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            S_MUL1, S_MUL2, S_MUL3: begin
                r_prod <= PW'(w_mul_a) * PW'(w_mul_b);
            end
            S_RND1, S_RND2: begin
                r_p <= w_rmag;
                if (w_rsat) begin
                    r_sat <= 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_mag <= {1'b0, w_quo[MAG_W-1:0]};
                    r_neg <= !r_neg;
                    if (r_action == ACT_TOL) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sum    <= r_sum;
            r_out_status <= r_sat ? ST_SAT : (r_limit ? ST_LIMIT : ST_OK);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.sum_value = r_out_sum;
    assign o_rsp.status    = r_out_status;

endmodule
